>>> rtl/core/adt_pkg.sv
package adt_pkg;

  // Default values of the top-level parameters
  localparam int unsigned WINDOW_DEPTH_DEF      = 64;
  localparam int unsigned EVAL_INTERVAL_SEC_DEF = 10;
  localparam int unsigned MIN_CLOSED_DEF        = 5;

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;

  // Per-event flag word held in the ring
  localparam int unsigned FLAG_W = 3;
  typedef logic [FLAG_W-1:0] flags_t;

  localparam int unsigned FLAG_BIT_ONGOING = 0;
  localparam int unsigned FLAG_BIT_FALSE   = 1;
  localparam int unsigned FLAG_BIT_TRUE    = 2;

  localparam flags_t FLAGS_ONGOING = 3'b001;
  localparam flags_t FLAGS_FALSE   = 3'b010;
  localparam flags_t FLAGS_TRUE    = 3'b100;
  localparam flags_t FLAGS_CLOSED  = 3'b000;

  // Configuration reset values
  localparam logic [15:0] RST_MIN_THRESHOLD = 16'd768;
  localparam logic [15:0] RST_MAX_THRESHOLD = 16'd3072;
  localparam logic [15:0] RST_INIT_THRESHOLD = 16'd1536;
  localparam logic [15:0] RST_STEP_SIZE     = 16'd128;
  localparam logic [15:0] RST_FP_RATE_LIMIT = 16'd13107;
  localparam logic [15:0] RST_TP_RATE_MIN   = 16'd32768;
  localparam logic [31:0] RST_FP_DURATION   = 32'd5000;
  localparam logic [31:0] RST_TP_DURATION   = 32'd30000;
  // Reset initial level already lies inside the reset bounds
  localparam logic [15:0] RST_LEVEL         = RST_INIT_THRESHOLD;

  typedef enum logic [2:0] {
    CFG_MIN_THRESHOLD  = 3'd0,
    CFG_MAX_THRESHOLD  = 3'd1,
    CFG_INIT_THRESHOLD = 3'd2,
    CFG_STEP_SIZE      = 3'd3,
    CFG_FP_RATE_LIMIT  = 3'd4,
    CFG_TP_RATE_MIN    = 3'd5,
    CFG_FP_DURATION    = 3'd6,
    CFG_TP_DURATION    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_END   = 2'd1,
    KIND_EVAL  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DIR_HOLD  = 2'd0,
    DIR_RAISE = 2'd1,
    DIR_LOWER = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    CLS_AMBIG = 2'd0,
    CLS_FALSE = 2'd1,
    CLS_TRUE  = 2'd2,
    CLS_NONE  = 2'd3
  } cls_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_END_SCAN,
    ST_EVAL_CHECK,
    ST_EVAL_SCAN,
    ST_MUL_FP,
    ST_MUL_TP,
    ST_DECIDE,
    ST_ADJUST,
    ST_CLAMP
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] time_ns;
    logic [31:0] duration_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] threshold;
    dir_e        adjust_dir;
    logic [6:0]  window_closed;
    logic [6:0]  window_false;
    logic [6:0]  window_true;
    cls_e        end_class;
  } out_item_t;

endpackage

>>> rtl/core/adaptive_detection_threshold_core.sv
// Adaptive detection threshold.
// Command channel: present an item on cmd_i with start_i high; it is taken at
// a rising edge where busy_o is low. Each item yields exactly one result on
// result_o, marked by done_o for a single cycle; the receiver cannot stall it.
// Start and no-op items finish at once: the result shows the cycle after
// acceptance and busy_o never rises. An end item walks the ring newest first,
// one read of the event memory per cycle, until it finds an ongoing event or
// has read every event held (up to WINDOW_DEPTH). An evaluate item ends in its
// check state when the interval has not elapsed; otherwise it reads every entry
// held, one memory read per cycle, ends there if fewer than MIN_CLOSED entries
// are closed, and else goes on through the states for the two rate products on
// the shared multiplier, the decision, the adjustment and the final clamp. The
// ring walk sets the rate.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once
// and belong only to idle periods; writing the initial threshold reloads the
// level, clamped to the current bounds.
// Reset loads the default registers and an empty ring; ring entries are
// never read before they are written, so the memory needs no clearing pass.
module adaptive_detection_threshold_core #(
  parameter int unsigned WINDOW_DEPTH      = adt_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned EVAL_INTERVAL_SEC = adt_pkg::EVAL_INTERVAL_SEC_DEF,
  parameter int unsigned MIN_CLOSED        = adt_pkg::MIN_CLOSED_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  adt_pkg::in_item_t   cmd_i,
  output logic                busy_o,
  output logic                done_o,
  output adt_pkg::out_item_t  result_o,
  input  logic                cfg_we_i,
  input  adt_pkg::cfg_idx_e   cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i
);

  localparam int unsigned IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned COEF_W = 19;
  localparam int unsigned PROD_W = CNT_W + COEF_W;
  localparam int unsigned T5_W   = CNT_W + 3;
  localparam int unsigned F10_W  = CNT_W + 4;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
  localparam logic [63:0] EVAL_SPAN_NS = 64'(EVAL_INTERVAL_SEC) * adt_pkg::NS_PER_SEC;
  localparam logic [31:0] MIN_SAMP     = 32'(MIN_CLOSED);

  // Min is tested first and max last, so inverted bounds yield max
  function automatic logic [15:0] clamp_level(input logic [15:0] v,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic [15:0] r;
    r = (v < lo) ? lo : v;
    r = (r > hi) ? hi : r;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  // Configuration registers
  logic [15:0] min_thr_q, max_thr_q, init_thr_q, step_q, fp_limit_q, tp_min_q;
  logic [31:0] fp_dur_q, tp_dur_q;

  // Sequencer and block state
  adt_pkg::state_e   state_q, state_d;
  adt_pkg::in_item_t cmd_q, cmd_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [63:0]       last_eval_q, last_eval_d;
  logic [15:0]       level_q, level_d;
  logic [CNT_W-1:0]  closed_cnt_q, closed_cnt_d;
  logic [CNT_W-1:0]  fp_cnt_q, fp_cnt_d;
  logic [CNT_W-1:0]  tp_cnt_q, tp_cnt_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_ptr_q, pend_ptr_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              raise_q, raise_d;
  logic              lower_q, lower_d;
  logic [15:0]       target_q, target_d;
  adt_pkg::dir_e     dir_q, dir_d;
  logic              done_q;
  adt_pkg::out_item_t result_q;

  // Ring port and shared datapath
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  adt_pkg::flags_t   wr_data;
  adt_pkg::flags_t   rd_data;
  logic              emit;
  adt_pkg::dir_e     emit_dir;
  adt_pkg::cls_e     emit_cls;
  logic [COEF_W-1:0] mul_a;
  logic [PROD_W-1:0] mul_p;
  logic [63:0]       elapsed;
  logic              scan_issue, scan_done;
  logic [PROD_W-1:0] fp_shift, tp_shift;
  logic [T5_W-1:0]   tp_x5;
  logic [F10_W-1:0]  fp_x10;
  logic [COEF_W-1:0] tp_coef;
  logic [16:0]       inc, lower_edge;
  logic [17:0]       raised;

  adt_ring #(
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (ptr_q),
    .rdata_o (rd_data)
  );

  // The one multiplier: fp limit times closed, then tp coefficient times closed
  assign mul_p   = PROD_W'(mul_a) * PROD_W'(closed_cnt_q);
  assign elapsed = cmd_q.time_ns - last_eval_q;

  assign fp_shift = PROD_W'({fp_cnt_q, 16'h0000});
  assign tp_x5    = T5_W'({tp_cnt_q, 2'b00}) + T5_W'(tp_cnt_q);
  assign tp_shift = {tp_x5, 16'h0000};
  assign fp_x10   = F10_W'({fp_cnt_q, 3'b000}) + F10_W'({fp_cnt_q, 1'b0});
  assign tp_coef  = COEF_W'({tp_min_q, 2'b00}) + COEF_W'(tp_min_q) + COEF_W'(17'h10000);

  assign inc        = ({fp_cnt_q, 1'b0} > {1'b0, closed_cnt_q}) ? {step_q, 1'b0}
                                                                : {1'b0, step_q};
  assign raised     = {2'b00, level_q} + {1'b0, inc};
  assign lower_edge = {1'b0, target_q} + {2'b00, step_q[15:1]};

  assign scan_issue = issue_q < count_q;
  assign scan_done  = !pend_q && !scan_issue;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    head_d       = head_q;
    count_d      = count_q;
    last_eval_d  = last_eval_q;
    level_d      = level_q;
    closed_cnt_d = closed_cnt_q;
    fp_cnt_d     = fp_cnt_q;
    tp_cnt_d     = tp_cnt_q;
    ptr_d        = ptr_q;
    issue_d      = issue_q;
    pend_d       = pend_q;
    pend_ptr_d   = pend_ptr_q;
    prod_d       = prod_q;
    raise_d      = raise_q;
    lower_d      = lower_q;
    target_d     = target_q;
    dir_d        = dir_q;
    emit         = 1'b0;
    emit_dir     = adt_pkg::DIR_HOLD;
    emit_cls     = adt_pkg::CLS_AMBIG;
    wr_en        = 1'b0;
    wr_addr      = head_q;
    wr_data      = adt_pkg::FLAGS_ONGOING;
    mul_a        = '0;

    unique case (state_q)
      adt_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          unique case (cmd_i.kind)
            adt_pkg::KIND_START: begin
              // Open an ongoing event at the head, saturate the fill count
              wr_en  = 1'b1;
              head_d = ptr_inc(head_q);
              if (count_q < DEPTH_CNT) begin
                count_d = count_q + 1'b1;
              end
              emit = 1'b1;
            end
            adt_pkg::KIND_END: begin
              ptr_d   = ptr_dec(head_q);
              issue_d = '0;
              pend_d  = 1'b0;
              state_d = adt_pkg::ST_END_SCAN;
            end
            adt_pkg::KIND_EVAL: begin
              state_d = adt_pkg::ST_EVAL_CHECK;
            end
            adt_pkg::KIND_NOP: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      adt_pkg::ST_END_SCAN: begin
        // Issue one read per cycle, newest entry first
        if (scan_issue) begin
          pend_d     = 1'b1;
          pend_ptr_d = ptr_q;
          ptr_d      = ptr_dec(ptr_q);
          issue_d    = issue_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && rd_data[adt_pkg::FLAG_BIT_ONGOING]) begin
          wr_en   = 1'b1;
          wr_addr = pend_ptr_q;
          if (cmd_q.duration_ms < fp_dur_q) begin
            wr_data  = adt_pkg::FLAGS_FALSE;
            emit_cls = adt_pkg::CLS_FALSE;
          end else if (cmd_q.duration_ms >= tp_dur_q) begin
            wr_data  = adt_pkg::FLAGS_TRUE;
            emit_cls = adt_pkg::CLS_TRUE;
          end else begin
            wr_data  = adt_pkg::FLAGS_CLOSED;
            emit_cls = adt_pkg::CLS_AMBIG;
          end
          emit    = 1'b1;
          state_d = adt_pkg::ST_IDLE;
        end else if (scan_done) begin
          emit_cls = adt_pkg::CLS_NONE;
          emit     = 1'b1;
          state_d  = adt_pkg::ST_IDLE;
        end
      end

      adt_pkg::ST_EVAL_CHECK: begin
        if (elapsed < EVAL_SPAN_NS) begin
          emit    = 1'b1;
          state_d = adt_pkg::ST_IDLE;
        end else begin
          last_eval_d  = cmd_q.time_ns;
          closed_cnt_d = '0;
          fp_cnt_d     = '0;
          tp_cnt_d     = '0;
          ptr_d        = '0;
          issue_d      = '0;
          pend_d       = 1'b0;
          state_d      = adt_pkg::ST_EVAL_SCAN;
        end
      end

      adt_pkg::ST_EVAL_SCAN: begin
        // Recount closed entries in slot order
        if (scan_issue) begin
          pend_d  = 1'b1;
          ptr_d   = ptr_inc(ptr_q);
          issue_d = issue_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && !rd_data[adt_pkg::FLAG_BIT_ONGOING]) begin
          closed_cnt_d = closed_cnt_q + 1'b1;
          if (rd_data[adt_pkg::FLAG_BIT_FALSE]) begin
            fp_cnt_d = fp_cnt_q + 1'b1;
          end
          if (rd_data[adt_pkg::FLAG_BIT_TRUE]) begin
            tp_cnt_d = tp_cnt_q + 1'b1;
          end
        end
        if (scan_done) begin
          if (32'(closed_cnt_q) < MIN_SAMP) begin
            emit    = 1'b1;
            state_d = adt_pkg::ST_IDLE;
          end else begin
            state_d = adt_pkg::ST_MUL_FP;
          end
        end
      end

      adt_pkg::ST_MUL_FP: begin
        mul_a   = COEF_W'(fp_limit_q);
        prod_d  = mul_p;
        state_d = adt_pkg::ST_MUL_TP;
      end

      adt_pkg::ST_MUL_TP: begin
        raise_d  = fp_shift > prod_q;
        mul_a    = tp_coef;
        prod_d   = mul_p;
        target_d = clamp_level(init_thr_q, min_thr_q, max_thr_q);
        state_d  = adt_pkg::ST_DECIDE;
      end

      adt_pkg::ST_DECIDE: begin
        lower_d = (fp_x10 < F10_W'(closed_cnt_q)) && (tp_shift > prod_q);
        state_d = adt_pkg::ST_ADJUST;
      end

      adt_pkg::ST_ADJUST: begin
        dir_d = adt_pkg::DIR_HOLD;
        if (raise_q) begin
          level_d = (raised > {2'b00, max_thr_q}) ? max_thr_q : raised[15:0];
          dir_d   = adt_pkg::DIR_RAISE;
        end else if (lower_q && (level_q > target_q)) begin
          // Drop half a step, never below the target
          level_d = ({1'b0, level_q} < lower_edge) ? target_q
                                                   : level_q - {1'b0, step_q[15:1]};
          dir_d   = adt_pkg::DIR_LOWER;
        end
        state_d = adt_pkg::ST_CLAMP;
      end

      adt_pkg::ST_CLAMP: begin
        level_d  = clamp_level(level_q, min_thr_q, max_thr_q);
        emit     = 1'b1;
        emit_dir = dir_q;
        state_d  = adt_pkg::ST_IDLE;
      end

      default: begin
        state_d = adt_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_thr_q  <= adt_pkg::RST_MIN_THRESHOLD;
      max_thr_q  <= adt_pkg::RST_MAX_THRESHOLD;
      init_thr_q <= adt_pkg::RST_INIT_THRESHOLD;
      step_q     <= adt_pkg::RST_STEP_SIZE;
      fp_limit_q <= adt_pkg::RST_FP_RATE_LIMIT;
      tp_min_q   <= adt_pkg::RST_TP_RATE_MIN;
      fp_dur_q   <= adt_pkg::RST_FP_DURATION;
      tp_dur_q   <= adt_pkg::RST_TP_DURATION;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        adt_pkg::CFG_MIN_THRESHOLD:  min_thr_q  <= cfg_wdata_i[15:0];
        adt_pkg::CFG_MAX_THRESHOLD:  max_thr_q  <= cfg_wdata_i[15:0];
        adt_pkg::CFG_INIT_THRESHOLD: init_thr_q <= cfg_wdata_i[15:0];
        adt_pkg::CFG_STEP_SIZE:      step_q     <= cfg_wdata_i[15:0];
        adt_pkg::CFG_FP_RATE_LIMIT:  fp_limit_q <= cfg_wdata_i[15:0];
        adt_pkg::CFG_TP_RATE_MIN:    tp_min_q   <= cfg_wdata_i[15:0];
        adt_pkg::CFG_FP_DURATION:    fp_dur_q   <= cfg_wdata_i;
        adt_pkg::CFG_TP_DURATION:    tp_dur_q   <= cfg_wdata_i;
      endcase
    end
  end

  // Control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= adt_pkg::ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      last_eval_q  <= '0;
      level_q      <= adt_pkg::RST_LEVEL;
      closed_cnt_q <= '0;
      fp_cnt_q     <= '0;
      tp_cnt_q     <= '0;
      issue_q      <= '0;
      pend_q       <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      last_eval_q  <= last_eval_d;
      closed_cnt_q <= closed_cnt_d;
      fp_cnt_q     <= fp_cnt_d;
      tp_cnt_q     <= tp_cnt_d;
      issue_q      <= issue_d;
      pend_q       <= pend_d;
      done_q       <= emit;
      // A new initial threshold reloads the level within the bounds
      if (cfg_we_i && (cfg_idx_i == adt_pkg::CFG_INIT_THRESHOLD)) begin
        level_q <= clamp_level(cfg_wdata_i[15:0], min_thr_q, max_thr_q);
      end else begin
        level_q <= level_d;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    ptr_q      <= ptr_d;
    pend_ptr_q <= pend_ptr_d;
    prod_q     <= prod_d;
    raise_q    <= raise_d;
    lower_q    <= lower_d;
    target_q   <= target_d;
    dir_q      <= dir_d;
    if (emit) begin
      result_q.threshold     <= level_d;
      result_q.adjust_dir    <= emit_dir;
      result_q.window_closed <= 7'(closed_cnt_d);
      result_q.window_false  <= 7'(fp_cnt_d);
      result_q.window_true   <= 7'(tp_cnt_d);
      result_q.end_class     <= emit_cls;
    end
  end

  assign busy_o   = (state_q != adt_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  // A start item completes with done_o in the next cycle, busy_o staying low
  a_start_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (cmd_i.kind == adt_pkg::KIND_START) |=> done_o && !busy_o)
    else $error("start item did not complete in one cycle");

  // A result leaves only as the sequencer returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // The fill count never passes the ring depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("ring fill count beyond depth");

  // The walk never issues more reads than entries held
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == adt_pkg::ST_END_SCAN) || (state_q == adt_pkg::ST_EVAL_SCAN)
      |-> issue_q <= count_q)
    else $error("ring walk ran past the fill count");
`endif

endmodule

>>> rtl/core/adt_ring.sv
module adt_ring #(
  parameter int unsigned DEPTH = adt_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  adt_pkg::flags_t      wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output adt_pkg::flags_t      rdata_o
);

  adt_pkg::flags_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> dv/tb_adaptive_detection_threshold_core.sv
module tb_adaptive_detection_threshold_core;
  import adt_pkg::*;

  localparam int unsigned DEPTH        = WINDOW_DEPTH_DEF;
  localparam logic [63:0] EVAL_SPAN_NS = 64'(EVAL_INTERVAL_SEC_DEF) * NS_PER_SEC;
  // Slowest item is a full ring walk plus the decision pipeline; allow slack on top.
  localparam int unsigned TAIL_CYCLES = DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  in_item_t    cmd_i;
  logic        busy_o;
  logic        done_o;
  out_item_t   result_o;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  adaptive_detection_threshold_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the detector: event ring, evaluation state and registers.
  flags_t      event_ring [DEPTH];
  int unsigned ring_head;
  int unsigned ring_fill;
  logic [63:0] last_eval_ns;
  int unsigned level;
  int unsigned win_closed;
  int unsigned win_false;
  int unsigned win_true;
  int unsigned lo_thr;
  int unsigned hi_thr;
  int unsigned init_thr;
  int unsigned step_amt;
  int unsigned fp_limit;
  int unsigned tp_base;
  logic [31:0] fp_dur;
  logic [31:0] tp_dur;

  out_item_t   threshold_results_due [$];
  out_item_t   oldest_due;
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;
  logic        idling_on;
  // Wall clock of the detection stream, advanced by the random traffic.
  logic [63:0] event_clock_ns;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: end the run as failed once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("adaptive_detection_threshold_core verification failed");
      $finish;
    end
  end

  // Clamp tests the minimum first, so inverted bounds resolve to the maximum.
  function automatic int unsigned clamp_to_bounds(int unsigned v);
    if (v < lo_thr) v = lo_thr;
    if (v > hi_thr) v = hi_thr;
    return v;
  endfunction

  // Advance the shadow detector by one item and return the result it produces.
  function automatic out_item_t next_threshold_result(in_item_t it);
    out_item_t   r;
    dir_e        dir;
    cls_e        cls;
    int unsigned idx;
    int unsigned inc;
    int unsigned half;
    int unsigned target;
    logic        found;
    logic [63:0] c;
    logic [63:0] f;
    logic [63:0] t;
    dir = DIR_HOLD;
    cls = CLS_AMBIG;
    case (it.kind)
      KIND_START: begin
        event_ring[ring_head] = FLAGS_ONGOING;
        ring_head = (ring_head + 1) % DEPTH;
        if (ring_fill < DEPTH) ring_fill++;
      end
      KIND_END: begin
        // Walk newest first and close the first ongoing event.
        cls = CLS_NONE;
        found = 1'b0;
        for (int i = 0; i < ring_fill && !found; i++) begin
          idx = (ring_head + DEPTH - 1 - i) % DEPTH;
          if (event_ring[idx][FLAG_BIT_ONGOING]) begin
            found = 1'b1;
            if (it.duration_ms < fp_dur) begin
              event_ring[idx] = FLAGS_FALSE;
              cls = CLS_FALSE;
            end else if (it.duration_ms >= tp_dur) begin
              event_ring[idx] = FLAGS_TRUE;
              cls = CLS_TRUE;
            end else begin
              event_ring[idx] = FLAGS_CLOSED;
              cls = CLS_AMBIG;
            end
          end
        end
      end
      KIND_EVAL: begin
        // Elapsed time wraps at 64 bits, so time going backwards looks long.
        if (it.time_ns - last_eval_ns >= EVAL_SPAN_NS) begin
          last_eval_ns = it.time_ns;
          win_closed = 0;
          win_false = 0;
          win_true = 0;
          for (int i = 0; i < ring_fill; i++) begin
            if (!event_ring[i][FLAG_BIT_ONGOING]) begin
              win_closed++;
              if (event_ring[i][FLAG_BIT_FALSE]) win_false++;
              if (event_ring[i][FLAG_BIT_TRUE]) win_true++;
            end
          end
          if (win_closed >= MIN_CLOSED_DEF) begin
            c = win_closed;
            f = win_false;
            t = win_true;
            if ((f << 16) > 64'(fp_limit) * c) begin
              inc = (2 * f > c) ? 2 * step_amt : step_amt;
              level = level + inc;
              if (level > hi_thr) level = hi_thr;
              dir = DIR_RAISE;
            end else if (10 * f < c &&
                         t * 64'd327680 > (64'd5 * tp_base + 64'd65536) * c) begin
              target = clamp_to_bounds(init_thr);
              if (level > target) begin
                half = step_amt >> 1;
                if (level < target + half) level = target;
                else level = level - half;
                if (level < target) level = target;
                dir = DIR_LOWER;
              end
            end
            level = clamp_to_bounds(level);
          end
        end
      end
      default: ;
    endcase
    r.threshold     = level[15:0];
    r.adjust_dir    = dir;
    r.window_closed = win_closed[6:0];
    r.window_false  = win_false[6:0];
    r.window_true   = win_true[6:0];
    r.end_class     = cls;
    return r;
  endfunction

  task automatic reset_shadow();
    lo_thr       = RST_MIN_THRESHOLD;
    hi_thr       = RST_MAX_THRESHOLD;
    init_thr     = RST_INIT_THRESHOLD;
    step_amt     = RST_STEP_SIZE;
    fp_limit     = RST_FP_RATE_LIMIT;
    tp_base      = RST_TP_RATE_MIN;
    fp_dur       = RST_FP_DURATION;
    tp_dur       = RST_TP_DURATION;
    ring_head    = 0;
    ring_fill    = 0;
    last_eval_ns = '0;
    level        = clamp_to_bounds(init_thr);
    win_closed   = 0;
    win_false    = 0;
    win_true     = 0;
  endtask

  function automatic in_item_t make_item(kind_e k, logic [63:0] t_ns, logic [31:0] dur);
    in_item_t it;
    it.kind        = k;
    it.time_ns     = t_ns;
    it.duration_ms = dur;
    return it;
  endfunction

  // Pick an event length: short, long or in between by the given mix, sometimes
  // right on a boundary, sometimes any value at all.
  function automatic logic [31:0] pick_duration(int unsigned false_pct, int unsigned true_pct);
    int unsigned r;
    logic [31:0] d;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      case ($urandom_range(0, 3))
        0:       d = fp_dur;
        1:       d = fp_dur - 1;
        2:       d = tp_dur;
        default: d = tp_dur - 1;
      endcase
    end else if (r < 8) begin
      d = $urandom;
    end else if (r < 8 + false_pct) begin
      d = (fp_dur == 0) ? $urandom : $urandom_range(0, fp_dur - 1);
    end else if (r < 8 + false_pct + true_pct) begin
      d = tp_dur + $urandom_range(0, 60000);
      if (d < tp_dur) d = '1;
    end else begin
      if (tp_dur > fp_dur) d = $urandom_range(fp_dur, tp_dur - 1);
      else d = $urandom;
    end
    return d;
  endfunction

  // Drop start and hold the line quiet for the requested idle gap.
  task automatic idle_cycles(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Present one item, hold it until taken, then record its result.
  // Start stays high on return unless a random pause drops it, so back-to-back items keep it up.
  task automatic send_item(in_item_t it);
    cmd_i   <= it;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    threshold_results_due.push_back(next_threshold_result(it));
    items_sent++;
    if (idling_on && $urandom_range(0, 99) < 20) idle_cycles($urandom_range(1, 8));
  endtask

  // Hold off new items until every result is back and the block is idle.
  task automatic drain_results();
    start_i <= 1'b0;
    while (threshold_results_due.size() != 0) @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_MIN_THRESHOLD:  lo_thr = value[15:0];
      CFG_MAX_THRESHOLD:  hi_thr = value[15:0];
      CFG_INIT_THRESHOLD: begin
        // Writing the initial level also reloads the live level.
        init_thr = value[15:0];
        level = clamp_to_bounds(init_thr);
      end
      CFG_STEP_SIZE:      step_amt = value[15:0];
      CFG_FP_RATE_LIMIT:  fp_limit = value[15:0];
      CFG_TP_RATE_MIN:    tp_base = value[15:0];
      CFG_FP_DURATION:    fp_dur = value;
      CFG_TP_DURATION:    tp_dur = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random detection traffic: mostly well-formed start/end pairs and periodic
  // evaluates, plus lone starts and ends, early evaluates and raw noise.
  task automatic drive_random_traffic(int unsigned count, int unsigned false_pct,
                                      int unsigned true_pct);
    int unsigned stop_at;
    int unsigned r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_item(make_item(KIND_START, {$urandom, $urandom}, $urandom));
        send_item(make_item(KIND_END, {$urandom, $urandom}, pick_duration(false_pct, true_pct)));
      end else if (r < 55) begin
        send_item(make_item(KIND_START, {$urandom, $urandom}, $urandom));
      end else if (r < 62) begin
        send_item(make_item(KIND_END, {$urandom, $urandom}, pick_duration(false_pct, true_pct)));
      end else if (r < 85) begin
        r = $urandom_range(0, 99);
        if (r < 75)
          event_clock_ns = event_clock_ns + EVAL_SPAN_NS + 64'($urandom_range(0, 32'd3000000000));
        else if (r < 92)
          event_clock_ns = event_clock_ns + 64'($urandom_range(0, 32'd999999999));
        else
          event_clock_ns = {$urandom, $urandom};
        send_item(make_item(KIND_EVAL, event_clock_ns, $urandom));
      end else begin
        send_item(make_item(kind_e'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom));
      end
    end
  endtask

  // Reset values show on a no-op; an end finds nothing; an evaluate at time
  // zero is too early.
  task automatic test_reset_state();
    send_item(make_item(KIND_NOP, {$urandom, $urandom}, $urandom));
    send_item(make_item(KIND_END, '0, '0));
    send_item(make_item(KIND_EVAL, '0, '1));
  endtask

  // Classification on every duration boundary, too few samples, a raise,
  // an early evaluate, time going backwards and the top of the time range.
  task automatic test_event_classification();
    repeat (6) send_item(make_item(KIND_START, '0, '0));
    send_item(make_item(KIND_END, '1, '0));
    send_item(make_item(KIND_END, '0, fp_dur - 1));
    send_item(make_item(KIND_END, '0, fp_dur));
    send_item(make_item(KIND_EVAL, EVAL_SPAN_NS, '0));
    send_item(make_item(KIND_END, '0, tp_dur - 1));
    send_item(make_item(KIND_END, '0, tp_dur));
    send_item(make_item(KIND_END, '0, '1));
    send_item(make_item(KIND_END, '0, '0));
    send_item(make_item(KIND_EVAL, 2 * EVAL_SPAN_NS, '0));
    send_item(make_item(KIND_EVAL, 2 * EVAL_SPAN_NS + 1, '0));
    send_item(make_item(KIND_EVAL, 64'd5, '0));
    send_item(make_item(KIND_EVAL, '1, '0));
    // Nested starts: the end closes the newer one.
    send_item(make_item(KIND_START, '0, '0));
    send_item(make_item(KIND_START, '0, '0));
    send_item(make_item(KIND_END, '0, tp_dur + 10000));
    send_item(make_item(KIND_NOP, {$urandom, $urandom}, $urandom));
    event_clock_ns = '1;
  endtask

  // Load one register setting and run two traffic mixes under it: the first
  // to push the level around, the second to pull it back.
  task automatic run_setting(logic [15:0] lo, logic [15:0] hi, logic [15:0] init,
                             logic [15:0] step, logic [15:0] fpl, logic [15:0] tpm,
                             logic [31:0] fpd, logic [31:0] tpd,
                             int unsigned na, int unsigned fa, int unsigned ta,
                             int unsigned nb, int unsigned fb, int unsigned tb);
    drain_results();
    write_reg(CFG_MIN_THRESHOLD, 32'(lo));
    write_reg(CFG_MAX_THRESHOLD, 32'(hi));
    write_reg(CFG_INIT_THRESHOLD, 32'(init));
    write_reg(CFG_STEP_SIZE, 32'(step));
    write_reg(CFG_FP_RATE_LIMIT, 32'(fpl));
    write_reg(CFG_TP_RATE_MIN, 32'(tpm));
    write_reg(CFG_FP_DURATION, fpd);
    write_reg(CFG_TP_DURATION, tpd);
    drive_random_traffic(na, fa, ta);
    drive_random_traffic(nb, fb, tb);
  endtask

  task automatic test_register_settings();
    // Defaults written back explicitly.
    run_setting(16'd768, 16'd3072, 16'd1536, 16'd128, 16'd13107, 16'd32768,
                32'd5000, 32'd30000, 40, 60, 30, 60, 3, 92);
    // Rates, durations, minimum and initial level at zero: no event is short, every event is long.
    run_setting(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0,
                32'd0, 32'd0, 30, 40, 40, 30, 0, 100);
    // Everything at the top.
    run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 30, 50, 40, 30, 50, 40);
    // Inverted bounds resolve to the maximum.
    run_setting(16'd4000, 16'd1000, 16'd2000, 16'd300, 16'd13107, 16'd32768,
                32'd5000, 32'd30000, 30, 60, 30, 30, 5, 90);
    // Odd step for the truncated half step; long clean stretch to lower.
    run_setting(16'd256, 16'd8000, 16'd512, 16'd1001, 16'd30000, 16'd6553,
                32'd100, 32'd1000, 30, 75, 20, 90, 2, 95);
    // Initial level above the maximum, tiny step, zero base rate.
    run_setting(16'd1024, 16'd4096, 16'd5000, 16'd3, 16'd13107, 16'd0,
                32'd20, 32'd40, 40, 55, 30, 40, 4, 90);
  endtask

  // Stop the sender now and then until every result is back.
  task automatic test_pause_until_drained();
    repeat (5) begin
      drive_random_traffic(12, 25, 45);
      drain_results();
    end
  endtask

  // Last stretch with no gaps at all.
  task automatic test_back_to_back();
    idling_on = 1'b0;
    drive_random_traffic(120, 25, 45);
  endtask

  // Compare one field of a result and count a mismatch.
  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Match each strobed result against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (threshold_results_due.size() == 0) begin
        $display("%0t: result with nothing outstanding: expected none, actual %h",
                 $time, result_o);
        mismatch_count++;
      end else begin
        oldest_due = threshold_results_due.pop_front();
        compare_field("threshold", oldest_due.threshold, result_o.threshold);
        compare_field("adjust_dir", oldest_due.adjust_dir, result_o.adjust_dir);
        compare_field("window_closed", oldest_due.window_closed, result_o.window_closed);
        compare_field("window_false", oldest_due.window_false, result_o.window_false);
        compare_field("window_true", oldest_due.window_true, result_o.window_true);
        compare_field("end_class", oldest_due.end_class, result_o.end_class);
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    cmd_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_MIN_THRESHOLD;
    cfg_wdata_i <= '0;
    idling_on      = 1'b1;
    event_clock_ns = '0;
    reset_shadow();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_event_classification();
    test_register_settings();
    test_pause_until_drained();
    test_back_to_back();

    // Wait out every outstanding result, then let the block settle.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && threshold_results_due.size() == 0) begin
      $display("adaptive_detection_threshold_core verification clean");
    end else begin
      $display("adaptive_detection_threshold_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/adt_pkg.sv
rtl/core/adt_ring.sv
rtl/core/adaptive_detection_threshold_core.sv
dv/tb_adaptive_detection_threshold_core.sv
